// ----- rtl/core/qoi_pkg.sv -----
// qoi_pkg: shared types and constants of the QOI-style pixel decoder.
// Used by qoi_cache, qoi_decode and qoi_style_pixel_decoder; depends on nothing.
package qoi_pkg;

    // Pending multi-byte op codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RGB  = 2'd1;
    localparam logic [1:0] OP_LUMA = 2'd2;

    // Op byte values and biases
    localparam logic [7:0] BYTE_RGB     = 8'hFE;
    localparam logic [7:0] BYTE_RUN_MIN = 8'hC0;
    localparam logic [7:0] BYTE_DIFF    = 8'h40;
    localparam logic [7:0] BYTE_LUMA    = 8'h80;
    localparam logic [7:0] DIFF_BIAS    = 8'd2;
    localparam logic [7:0] LUMA_G_BIAS  = 8'd32;
    localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

    // Bytes still expected by a raw RGB op
    localparam logic [1:0] LEFT_RED   = 2'd3;
    localparam logic [1:0] LEFT_GREEN = 2'd2;
    localparam logic [1:0] LEFT_BLUE  = 2'd1;

    localparam int PIX_W = 24;
    localparam int RUN_W = 6;

    typedef logic [PIX_W-1:0] pix_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] left;
        logic [7:0] part_red;
        logic [7:0] part_green;
        logic [7:0] luma_dg;
        logic       started;
        pix_t       prev;
    } qoi_state_t;

    // Result produced by one byte: one pixel, a run, or an error word
    typedef struct packed {
        logic             valid;
        logic             err;
        pix_t             pix;
        logic [RUN_W-1:0] run_m1;
    } qoi_res_t;

endpackage

// ----- rtl/core/qoi_cache.sv -----
// qoi_cache: color cache memory with per-entry valid bits and write forwarding.
// Depends on qoi_pkg for the pixel type.
module qoi_cache #(
    parameter int CACHE_ENTRIES = 64,
    parameter int IDX_W         = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clr,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  qoi_pkg::pix_t      wr_data,
    output qoi_pkg::pix_t      rd_pix
);

    qoi_pkg::pix_t            mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;
    qoi_pkg::pix_t            rd_mem_reg;
    logic                     rd_valid_reg;
    logic                     fwd_hit_reg;
    qoi_pkg::pix_t            fwd_data_reg;

    // Write the entry, read the addressed entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_mem_reg   <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Track written entries; clear all at once on reset or a new image
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= !clr && valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Forward a same-cycle write, read unwritten entries as zero
    assign rd_pix = fwd_hit_reg  ? fwd_data_reg :
                    rd_valid_reg ? rd_mem_reg   : '0;

endmodule

// ----- rtl/core/qoi_decode.sv -----
// qoi_decode: decodes one stream byte against the current state; pure logic.
// Depends on qoi_pkg for state and result types and op constants.
module qoi_decode #(
    parameter int IDX_W = 6
) (
    input  logic [7:0]          in_byte,
    input  logic                new_image,
    input  qoi_pkg::qoi_state_t state,
    input  qoi_pkg::pix_t       cache_pix,
    output qoi_pkg::qoi_state_t state_next,
    output qoi_pkg::qoi_res_t   res,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr
);

    qoi_pkg::qoi_state_t st;
    qoi_pkg::pix_t       pix;
    logic [7:0]          pr;
    logic [7:0]          pg;
    logic [7:0]          pb;
    logic [7:0]          dg;
    logic [11:0]         hsum;

    always_comb begin
        // Drop all state ahead of the first byte of a new image
        st = new_image ? qoi_pkg::qoi_state_t'('0) : state;
        pr = st.prev[23:16];
        pg = st.prev[15:8];
        pb = st.prev[7:0];
        dg = st.luma_dg;

        state_next = st;
        res        = '0;
        pix        = st.prev;
        wr_en      = 1'b0;

        priority if (st.op == qoi_pkg::OP_RGB) begin
            priority if (st.left == qoi_pkg::LEFT_RED) begin
                state_next.part_red = in_byte;
                state_next.left     = qoi_pkg::LEFT_GREEN;
            end else if (st.left == qoi_pkg::LEFT_GREEN) begin
                state_next.part_green = in_byte;
                state_next.left       = qoi_pkg::LEFT_BLUE;
            end else begin
                pix                = {st.part_red, st.part_green, in_byte};
                state_next.op      = qoi_pkg::OP_NONE;
                state_next.left    = '0;
                state_next.started = 1'b1;
                wr_en              = 1'b1;
                res.valid          = 1'b1;
            end
        end else if (st.op == qoi_pkg::OP_LUMA) begin
            pix = {pr + ({4'd0, in_byte[7:4]} + dg - qoi_pkg::LUMA_RB_BIAS),
                   pg + dg,
                   pb + ({4'd0, in_byte[3:0]} + dg - qoi_pkg::LUMA_RB_BIAS)};
            state_next.op   = qoi_pkg::OP_NONE;
            state_next.left = '0;
            wr_en           = 1'b1;
            res.valid       = 1'b1;
        end else begin
            state_next.op   = qoi_pkg::OP_NONE;
            state_next.left = '0;
            priority if (in_byte == qoi_pkg::BYTE_RGB) begin
                state_next.op   = qoi_pkg::OP_RGB;
                state_next.left = qoi_pkg::LEFT_RED;
            end else if (!st.started) begin
                // First op of the image is not raw RGB: flag it, no pixel
                pix       = '0;
                res.valid = 1'b1;
                res.err   = 1'b1;
            end else if (in_byte >= qoi_pkg::BYTE_RUN_MIN) begin
                // Repeat the previous pixel, store it again
                res.run_m1 = in_byte[qoi_pkg::RUN_W-1:0];
                wr_en      = 1'b1;
                res.valid  = 1'b1;
            end else if (in_byte < qoi_pkg::BYTE_DIFF) begin
                pix       = cache_pix;
                wr_en     = 1'b1;
                res.valid = 1'b1;
            end else if (in_byte < qoi_pkg::BYTE_LUMA) begin
                pix = {pr + {6'd0, in_byte[5:4]} - qoi_pkg::DIFF_BIAS,
                       pg + {6'd0, in_byte[3:2]} - qoi_pkg::DIFF_BIAS,
                       pb + {6'd0, in_byte[1:0]} - qoi_pkg::DIFF_BIAS};
                wr_en     = 1'b1;
                res.valid = 1'b1;
            end else begin
                state_next.luma_dg = {2'd0, in_byte[5:0]} - qoi_pkg::LUMA_G_BIAS;
                state_next.op      = qoi_pkg::OP_LUMA;
                state_next.left    = qoi_pkg::LEFT_BLUE;
            end
        end

        res.pix = pix;
        if (wr_en) begin
            state_next.prev = pix;
        end

        // Cache slot of the committed pixel
        hsum = 12'(pix[23:16]) * 12'd3 + 12'(pix[15:8]) * 12'd5 + 12'(pix[7:0]) * 12'd7;
    end

    assign wr_addr = hsum[IDX_W-1:0];

endmodule

// ----- rtl/core/qoi_style_pixel_decoder.sv -----
// qoi_style_pixel_decoder: top level of the QOI-style RGB stream decoder.
// Depends on qoi_pkg, qoi_cache and qoi_decode.
//
// Usage:
//   The slave channel takes one compressed byte per word in s_tdata; s_tuser
//   marks the first byte of a new image, which clears the color cache and all
//   decode state before the byte is used. The master channel gives one decoded
//   pixel per word, red/green/blue in m_tdata, m_tlast high on the last pixel
//   that one input byte yields, and m_tuser high on an error word (first op of
//   an image not raw RGB; pixel zero, m_tlast low).
//   An accepted byte waits in the input register; its first pixel enters the
//   output register when the byte is consumed. Throughput: one byte per cycle
//   while the output does not stall; bytes inside a multi-byte op produce no
//   word. A run op of N pixels occupies the output register for N words, and
//   the slave side stalls with the next byte held until the last word is taken.
//   Reset (aresetn low, synchronous) clears the valid bits of the color cache,
//   the previous pixel and the op state at once; no clearing pass is needed.
//   When m_tready is low the output word holds and, once the input register is
//   full, s_tready drops; nothing is lost or repeated.
module qoi_style_pixel_decoder #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tuser,    // [0] new_image
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic        m_tlast,    // run_last
    output logic        m_tuser     // [0] stream_error
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_new_reg;
    qoi_pkg::qoi_state_t       state_reg;
    qoi_pkg::qoi_state_t       state_next;
    qoi_pkg::qoi_res_t         res;
    qoi_pkg::pix_t             cache_pix;
    logic                      dec_wr_en;
    logic [IDX_W-1:0]          dec_wr_addr;
    logic                      out_valid_reg;
    logic                      out_err_reg;
    qoi_pkg::pix_t             out_pix_reg;
    logic [qoi_pkg::RUN_W-1:0] out_cnt_reg;
    logic                      adv;
    logic                      accept;
    logic                      out_last;

    // Consume the held byte once the output register frees up
    assign out_last = (out_cnt_reg == '0);
    assign adv      = in_valid_reg && (!out_valid_reg || (m_tready && out_last));
    assign s_tready = !in_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser;
        end
    end

    // Read the cache at the index of the incoming byte
    qoi_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (adv && in_new_reg),
        .rd_en   (accept),
        .rd_addr (s_tdata[IDX_W-1:0]),
        .wr_en   (adv && dec_wr_en),
        .wr_addr (dec_wr_addr),
        .wr_data (res.pix),
        .rd_pix  (cache_pix)
    );

    qoi_decode #(
        .IDX_W (IDX_W)
    ) u_decode (
        .in_byte    (in_byte_reg),
        .new_image  (in_new_reg),
        .state      (state_reg),
        .cache_pix  (cache_pix),
        .state_next (state_next),
        .res        (res),
        .wr_en      (dec_wr_en),
        .wr_addr    (dec_wr_addr)
    );

    // Advance decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    // Output register; a run counts its remaining words down
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
        end else if (adv && res.valid) begin
            out_valid_reg <= 1'b1;
            out_cnt_reg   <= res.run_m1;
        end else if (out_valid_reg && m_tready) begin
            if (out_last) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_cnt_reg <= out_cnt_reg - qoi_pkg::RUN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid) begin
            out_pix_reg <= res.pix;
            out_err_reg <= res.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg[7:0], out_pix_reg[15:8], out_pix_reg[23:16]};
    assign m_tlast  = out_last && !out_err_reg;
    assign m_tuser  = out_err_reg;

endmodule
